### sv/tcw_pkg.sv
package tcw_pkg;

   localparam int COLUMNS = 80;
   localparam int ROWS = 25;
   localparam int TOTAL = COLUMNS * ROWS;
   localparam int COPY_N = (ROWS - 1) * COLUMNS;
   localparam int ADDR_W = $clog2(TOTAL);
   localparam int COL_W = 7;
   localparam int ROW_W = 5;
   localparam int START_LINE = 19;
   localparam int RESET_LINE = (START_LINE < ROWS) ? START_LINE : (ROWS - 1);

   localparam logic [15:0] BLANK_CELL = 16'h0220;
   localparam logic [7:0] DEFAULT_ATTR = 8'h02;
   localparam logic [7:0] NEWLINE_CODE = 8'd10;

   typedef enum logic [1:0] {
      REQ_PUT    = 2'd0,
      REQ_PUT_AT = 2'd1,
      REQ_READ   = 2'd2,
      REQ_NONE   = 2'd3
   } req_code_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_SCROLL,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      logic [1:0]       req_type;
      logic [7:0]       char_code;
      logic [7:0]       attribute;
      logic [COL_W-1:0] target_col;
      logic [ROW_W-1:0] target_row;
   } text_req_type;

   typedef struct packed {
      logic [15:0]      cell_value;
      logic [COL_W-1:0] cursor_col;
      logic [ROW_W-1:0] cursor_row;
      logic             did_scroll;
   } text_rsp_type;

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [COL_W-1:0] col,
                                                   input logic [ROW_W-1:0] row);
      cell_addr = ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
   endfunction

endpackage

### sv/text_console_writer.sv
// put request: result in the cycle after acceptance, a new request can be accepted on the next edge
// read request: the cell is read into a register, then ST_READ registers it as the result
// a scrolling request walks the cell memory one entry per cycle, then ST_DRAIN registers the
// result; after reset busy stays high while the memory is blanked
// reset is synchronous and active high; cursor returns to column 0, row 19
// here the receiver cannot stall: every result is shown for one cycle on rsp_strobe
module text_console_writer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  tcw_pkg::text_req_type req_data,
   output logic                  rsp_strobe,
   output tcw_pkg::text_rsp_type rsp_data
);

   localparam logic [7:0] COLS_X = 8'(tcw_pkg::COLUMNS);
   localparam logic [5:0] ROWS_X = 6'(tcw_pkg::ROWS);

   logic [15:0] cell_mem [tcw_pkg::TOTAL];
   logic [15:0] rd_data_ff;

   logic                       mem_we;
   logic [tcw_pkg::ADDR_W-1:0] mem_wa;
   logic [15:0]                mem_wd;
   logic [tcw_pkg::ADDR_W-1:0] mem_ra;

   tcw_pkg::state_type         state_ff, state_in;
   logic [tcw_pkg::ADDR_W-1:0] cnt_ff, cnt_in;
   logic [tcw_pkg::COL_W-1:0]  col_ff, col_in;
   logic [tcw_pkg::ROW_W-1:0]  row_ff, row_in;
   logic                       wr_valid_ff, wr_valid_in;
   logic [tcw_pkg::ADDR_W-1:0] wr_addr_ff, wr_addr_in;
   logic                       wr_blank_ff, wr_blank_in;
   logic                       rsp_strobe_ff, rsp_strobe_in;
   tcw_pkg::text_rsp_type      rsp_data_ff, rsp_data_in;

   logic                      accept;
   tcw_pkg::req_code_type     code;
   logic                      in_screen;
   logic                      is_nl;
   logic                      do_print;
   logic [tcw_pkg::COL_W-1:0] col_c;
   logic [tcw_pkg::ROW_W-1:0] row_c;
   logic [7:0]                attr_c;
   logic [7:0]                col_next;
   logic [5:0]                row_next;
   logic                      wrap;
   logic                      scroll;
   logic [tcw_pkg::COL_W-1:0] new_col;
   logic [tcw_pkg::ROW_W-1:0] new_row;
   logic                      put_write;
   logic [15:0]               word;

   // cell memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         cell_mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= cell_mem[mem_ra];
   end

   assign accept = start && (state_ff == tcw_pkg::ST_IDLE);
   assign code = tcw_pkg::req_code_type'(req_data.req_type);
   assign in_screen = (req_data.target_col < tcw_pkg::COL_W'(tcw_pkg::COLUMNS)) &&
                      ({1'b0, req_data.target_row} < ROWS_X);

   always_comb begin
      if (code == tcw_pkg::REQ_PUT_AT) begin
         col_c = req_data.target_col;
         row_c = req_data.target_row;
         attr_c = tcw_pkg::DEFAULT_ATTR;
      end else begin
         col_c = col_ff;
         row_c = row_ff;
         attr_c = req_data.attribute;
      end
      is_nl = (req_data.char_code == tcw_pkg::NEWLINE_CODE);
      do_print = (code == tcw_pkg::REQ_PUT) || ((code == tcw_pkg::REQ_PUT_AT) && in_screen);
      col_next = {1'b0, col_c} + 8'd1;
      row_next = {1'b0, row_c} + 6'd1;
      wrap = is_nl || (col_next >= COLS_X);
      scroll = do_print && wrap && (row_next >= ROWS_X);
      if (!wrap) begin
         new_col = col_next[tcw_pkg::COL_W-1:0];
         new_row = row_c;
      end else if (scroll) begin
         new_col = '0;
         new_row = tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);
      end else begin
         new_col = '0;
         new_row = row_next[tcw_pkg::ROW_W-1:0];
      end
      put_write = do_print && !is_nl;
      word = {attr_c, req_data.char_code};
   end

   // memory port selection
   always_comb begin
      mem_we = 1'b0;
      mem_wa = tcw_pkg::cell_addr(col_c, row_c);
      mem_wd = word;
      mem_ra = tcw_pkg::cell_addr(req_data.target_col, req_data.target_row);
      if (wr_valid_ff) begin
         mem_we = 1'b1;
         mem_wa = wr_addr_ff;
         mem_wd = wr_blank_ff ? tcw_pkg::BLANK_CELL : rd_data_ff;
      end else if (state_ff == tcw_pkg::ST_CLEAR) begin
         mem_we = 1'b1;
         mem_wa = cnt_ff;
         mem_wd = tcw_pkg::BLANK_CELL;
      end else if (accept) begin
         mem_we = put_write;
      end
      if (state_ff == tcw_pkg::ST_SCROLL) begin
         mem_ra = cnt_ff + tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tcw_pkg::ST_CLEAR;
         cnt_ff <= '0;
         col_ff <= '0;
         row_ff <= tcw_pkg::ROW_W'(tcw_pkg::RESET_LINE);
         wr_valid_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         col_ff <= col_in;
         row_ff <= row_in;
         wr_valid_ff <= wr_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      wr_addr_ff <= wr_addr_in;
      wr_blank_ff <= wr_blank_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      col_in = col_ff;
      row_in = row_ff;
      wr_valid_in = 1'b0;
      wr_addr_in = cnt_ff;
      wr_blank_in = (cnt_ff >= tcw_pkg::ADDR_W'(tcw_pkg::COPY_N));
      rsp_strobe_in = 1'b0;
      rsp_data_in = rsp_data_ff;
      case (state_ff)
         tcw_pkg::ST_CLEAR: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == tcw_pkg::ADDR_W'(tcw_pkg::TOTAL - 1)) begin
               cnt_in = '0;
               state_in = tcw_pkg::ST_IDLE;
            end
         end
         tcw_pkg::ST_IDLE: begin
            if (accept) begin
               rsp_data_in.cell_value = put_write ? word : 16'h0000;
               rsp_data_in.cursor_col = col_ff;
               rsp_data_in.cursor_row = row_ff;
               rsp_data_in.did_scroll = scroll;
               if (code == tcw_pkg::REQ_PUT) begin
                  col_in = new_col;
                  row_in = new_row;
                  rsp_data_in.cursor_col = new_col;
                  rsp_data_in.cursor_row = new_row;
               end
               if (scroll) begin
                  cnt_in = '0;
                  state_in = tcw_pkg::ST_SCROLL;
               end else if ((code == tcw_pkg::REQ_READ) && in_screen) begin
                  state_in = tcw_pkg::ST_READ;
               end else begin
                  rsp_strobe_in = 1'b1;
               end
            end
         end
         tcw_pkg::ST_READ: begin
            rsp_data_in.cell_value = rd_data_ff;
            rsp_strobe_in = 1'b1;
            state_in = tcw_pkg::ST_IDLE;
         end
         tcw_pkg::ST_SCROLL: begin
            wr_valid_in = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == tcw_pkg::ADDR_W'(tcw_pkg::TOTAL - 1)) begin
               cnt_in = '0;
               state_in = tcw_pkg::ST_DRAIN;
            end
         end
         tcw_pkg::ST_DRAIN: begin
            rsp_strobe_in = 1'b1;
            state_in = tcw_pkg::ST_IDLE;
         end
         default: begin
            state_in = tcw_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != tcw_pkg::ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data = rsp_data_ff;

endmodule

### sv/tcw_checker.sv
module tcw_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input tcw_pkg::text_req_type req_data,
   input logic                  rsp_strobe,
   input tcw_pkg::text_rsp_type rsp_data
);

   // every request answers at once or holds busy
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (rsp_strobe || busy))
      else $error("request neither answered nor busy");

   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ((rsp_data.cursor_col < tcw_pkg::COL_W'(tcw_pkg::COLUMNS)) &&
                      (rsp_data.cursor_row < tcw_pkg::ROW_W'(tcw_pkg::ROWS))))
      else $error("cursor outside screen");

   // a scroll always costs busy cycles
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.did_scroll) |-> $past(busy))
      else $error("scroll result without busy period");

   // memory blanking follows reset
   assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> busy)
      else $error("not busy after reset");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_data.cell_value == 16'h0000)) |-> !$past(rsp_strobe && busy))
      else $error("strobe while busy");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (.*);
